// ----- rtl/rect_blit_copy_compare_unit_assert.svh -----
// Assertion macros shared by the rect blit copy/compare unit.
`ifndef RECT_BLIT_COPY_COMPARE_UNIT_ASSERT_SVH
`define RECT_BLIT_COPY_COMPARE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define RBCC_ASSERT_COMB(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rbcc assertion failed");
// consequent holds in the same cycle as the antecedent
`define RBCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbcc assertion failed");
// consequent holds in the cycle after the antecedent
`define RBCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbcc assertion failed");
`else
`define RBCC_ASSERT_COMB(label, cond)
`define RBCC_ASSERT_IMPL(label, ante, cons)
`define RBCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/rbcc_pkg.sv -----
// Types, constants and helper functions of the rect blit copy/compare unit.
`timescale 1ns / 1ps
package rbcc_pkg;

	localparam int SIZE_BITS_DEF = 24;
	localparam int DIM_BITS_DEF  = 12;

	localparam int STRIDE_W   = 16;
	localparam int SURF_W     = 25;
	localparam int RECT_DIM_W = 12;
	localparam int PSIZE_W    = 2;
	localparam int COORD_W    = 13;
	localparam int PIX_W      = 32;
	localparam int PTR_W      = 26;
	localparam int FAIL_W     = 24;
	localparam int PROD_W     = COORD_W + STRIDE_W + 1;
	localparam int ORG_W      = 32;
	localparam int SUM_W      = 28;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;

	// input tdata layout
	localparam int SX_LO     = 0;
	localparam int SY_LO     = SX_LO + COORD_W;
	localparam int DX_LO     = SY_LO + COORD_W;
	localparam int DY_LO     = DX_LO + COORD_W;
	localparam int SPIX_LO   = DY_LO + COORD_W;
	localparam int DPIX_LO   = SPIX_LO + PIX_W;
	localparam int IN_BITS   = DPIX_LO + PIX_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata layout
	localparam int SADR_LO    = 0;
	localparam int DADR_LO    = SADR_LO + PTR_W;
	localparam int WDATA_LO   = DADR_LO + PTR_W;
	localparam int FAIL_LO    = WDATA_LO + PIX_W;
	localparam int OUT_BITS   = FAIL_LO + FAIL_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;
	localparam int TU_INB      = 0;
	localparam int TU_WE       = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_SIZE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE = 3'd7;

	// commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// pixel size codes
	localparam logic [PSIZE_W-1:0] PIX_1B = 2'd0;
	localparam logic [PSIZE_W-1:0] PIX_2B = 2'd1;
	localparam logic [PSIZE_W-1:0] PIX_4B = 2'd2;

	localparam logic signed [ORG_W-1:0] PTR_HI = ORG_W'((64'sd1 <<< (PTR_W - 1)) - 64'sd1);
	localparam logic signed [ORG_W-1:0] PTR_LO = ORG_W'(-(64'sd1 <<< (PTR_W - 1)));

	typedef struct packed {
		logic [STRIDE_W-1:0]   src_stride;
		logic [SURF_W-1:0]     src_size;
		logic [STRIDE_W-1:0]   dst_stride;
		logic [SURF_W-1:0]     dst_size;
		logic [RECT_DIM_W-1:0] rect_width;
		logic [RECT_DIM_W-1:0] rect_height;
		logic [PSIZE_W-1:0]    pixel_size;
		logic                  compare_mode;
	} rbcc_cfg_t;

	// one classified item on its way from front to back
	typedef struct packed {
		logic                    cmd;
		logic signed [ORG_W-1:0] src_origin;
		logic signed [ORG_W-1:0] dst_origin;
		logic                    mismatch;
		logic [PIX_W-1:0]        pixel;
	} rbcc_item_t;

	// log2 of bytes per pixel; the unused code behaves as two bytes
	function automatic logic [1:0] bpp_shift(input logic [PSIZE_W-1:0] ps);
		logic [1:0] sh;
		case (ps)
			PIX_1B:  sh = 2'd0;
			PIX_2B:  sh = 2'd1;
			PIX_4B:  sh = 2'd2;
			default: sh = 2'd1;
		endcase
		return sh;
	endfunction

	function automatic logic [PIX_W-1:0] pix_mask(input logic [PSIZE_W-1:0] ps);
		logic [PIX_W-1:0] m;
		case (bpp_shift(ps))
			2'd0:    m = 32'h0000_00FF;
			2'd1:    m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic signed [PTR_W-1:0] sat_ptr(input logic signed [ORG_W-1:0] v);
		logic signed [PTR_W-1:0] r;
		if (v > PTR_HI)
			r = PTR_W'(PTR_HI);
		else if (v < PTR_LO)
			r = PTR_W'(PTR_LO);
		else
			r = PTR_W'(v);
		return r;
	endfunction

	function automatic logic in_surface(input logic signed [PTR_W-1:0] p,
			input logic [SURF_W-1:0] size);
		return !p[PTR_W-1] && (p[PTR_W-2:0] < size);
	endfunction

endpackage

// ----- rtl/rbcc_front.sv -----
// Front end: takes input items, computes start origins and pixel compare results.
`timescale 1ns / 1ps
module rbcc_front (
	input  rbcc_pkg::rbcc_cfg_t              cfg,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rbcc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tuser,
	output logic                             q_push,
	output rbcc_pkg::rbcc_item_t             q_item,
	input  logic                             q_full
);
	import rbcc_pkg::*;

	logic signed [COORD_W-1:0] sx, sy, dx, dy;
	logic [PIX_W-1:0]          spix, dpix, mask;
	logic [1:0]                shift;
	logic signed [PROD_W-1:0]  src_prod, dst_prod;
	logic signed [ORG_W-1:0]   sx_w, dx_w;

	assign sx   = s_tdata[SX_LO +: COORD_W];
	assign sy   = s_tdata[SY_LO +: COORD_W];
	assign dx   = s_tdata[DX_LO +: COORD_W];
	assign dy   = s_tdata[DY_LO +: COORD_W];
	assign spix = s_tdata[SPIX_LO +: PIX_W];
	assign dpix = s_tdata[DPIX_LO +: PIX_W];

	assign shift = bpp_shift(cfg.pixel_size);
	assign mask  = pix_mask(cfg.pixel_size);

	// row offset: signed row times unsigned stride
	assign src_prod = sy * $signed({1'b0, cfg.src_stride});
	assign dst_prod = dy * $signed({1'b0, cfg.dst_stride});
	assign sx_w     = ORG_W'(sx);
	assign dx_w     = ORG_W'(dx);

	always_comb begin
		q_item.cmd        = s_tuser;
		q_item.src_origin = ORG_W'(src_prod) + (sx_w <<< shift);
		q_item.dst_origin = ORG_W'(dst_prod) + (dx_w <<< shift);
		q_item.mismatch   = ((spix ^ dpix) & mask) != '0;
		q_item.pixel      = spix & mask;
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

// ----- rtl/rbcc_fifo.sv -----
// Small register queue between the front end and the walker.
`timescale 1ns / 1ps
module rbcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- rtl/rbcc_back.sv -----
// Back end: rectangle walker state, clipping, failure count and output register.
`timescale 1ns / 1ps
`include "rect_blit_copy_compare_unit_assert.svh"
module rbcc_back #(
	parameter int SIZE_BITS = rbcc_pkg::SIZE_BITS_DEF,
	parameter int DIM_BITS  = rbcc_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rbcc_pkg::rbcc_cfg_t               cfg,
	input  rbcc_pkg::rbcc_item_t              q_item,
	input  logic                              q_empty,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [rbcc_pkg::OUT_TUSER_W-1:0]  m_tuser,
	output logic                              m_tlast
);
	import rbcc_pkg::*;

	localparam int CW = (DIM_BITS > RECT_DIM_W) ? DIM_BITS : RECT_DIM_W;
	localparam logic [FAIL_W-1:0] FAIL_CAP = (SIZE_BITS >= FAIL_W) ? {FAIL_W{1'b1}} :
		FAIL_W'((64'd1 << SIZE_BITS) - 64'd1);

	// walker state
	logic signed [PTR_W-1:0] src_ptr_q, dst_ptr_q;
	logic [DIM_BITS-1:0]     col_q, row_q;
	logic [FAIL_W-1:0]       fail_q;
	logic                    busy_q;

	// output register
	logic                    out_valid_q;
	logic signed [PTR_W-1:0] out_src_q, out_dst_q;
	logic                    out_inb_q, out_we_q, out_done_q;
	logic [PIX_W-1:0]        out_wdata_q;
	logic [FAIL_W-1:0]       out_fail_q;

	logic [1:0]              shift;
	logic signed [SUM_W-1:0] bpp, wbytes, src_jump, dst_jump, src_sum, dst_sum;
	logic [DIM_BITS-1:0]     col_inc, row_inc;
	logic                    wrap, cur_ok, fail_hit;

	logic signed [PTR_W-1:0] src_n, dst_n;
	logic [DIM_BITS-1:0]     col_n, row_n;
	logic [FAIL_W-1:0]       fail_n;
	logic                    busy_n, we_n;
	logic [PIX_W-1:0]        wdata_n;

	assign q_pop = !q_empty && (!out_valid_q || m_tready);

	assign shift    = bpp_shift(cfg.pixel_size);
	assign bpp      = SUM_W'(1) << shift;
	assign wbytes   = SUM_W'(cfg.rect_width) << shift;
	// end of row: back over the row, then one stride down
	assign src_jump = bpp - wbytes + SUM_W'(cfg.src_stride);
	assign dst_jump = bpp - wbytes + SUM_W'(cfg.dst_stride);

	assign col_inc = col_q + DIM_BITS'(1);
	assign row_inc = row_q + DIM_BITS'(1);
	assign wrap    = CW'(col_inc) >= CW'(cfg.rect_width);
	assign src_sum = SUM_W'(src_ptr_q) + (wrap ? src_jump : bpp);
	assign dst_sum = SUM_W'(dst_ptr_q) + (wrap ? dst_jump : bpp);

	assign cur_ok   = in_surface(src_ptr_q, cfg.src_size) && in_surface(dst_ptr_q, cfg.dst_size);
	assign fail_hit = (!cur_ok || q_item.mismatch) && (fail_q < FAIL_CAP);

	always_comb begin
		src_n   = src_ptr_q;
		dst_n   = dst_ptr_q;
		col_n   = col_q;
		row_n   = row_q;
		fail_n  = fail_q;
		busy_n  = busy_q;
		we_n    = 1'b0;
		wdata_n = '0;
		if (q_item.cmd == CMD_START) begin
			src_n  = sat_ptr(q_item.src_origin);
			dst_n  = sat_ptr(q_item.dst_origin);
			col_n  = '0;
			row_n  = '0;
			fail_n = '0;
			busy_n = (cfg.rect_width != '0) && (cfg.rect_height != '0);
		end else if (busy_q) begin
			if (cfg.compare_mode) begin
				if (fail_hit)
					fail_n = fail_q + FAIL_W'(1);
			end else if (cur_ok) begin
				we_n    = 1'b1;
				wdata_n = q_item.pixel;
			end
			if (wrap) begin
				col_n = '0;
				row_n = row_inc;
				if (CW'(row_inc) >= CW'(cfg.rect_height))
					busy_n = 1'b0;
			end else begin
				col_n = col_inc;
			end
			src_n = sat_ptr(ORG_W'(src_sum));
			dst_n = sat_ptr(ORG_W'(dst_sum));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ptr_q   <= '0;
			dst_ptr_q   <= '0;
			col_q       <= '0;
			row_q       <= '0;
			fail_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				src_ptr_q   <= src_n;
				dst_ptr_q   <= dst_n;
				col_q       <= col_n;
				row_q       <= row_n;
				fail_q      <= fail_n;
				busy_q      <= busy_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_src_q   <= src_n;
			out_dst_q   <= dst_n;
			out_inb_q   <= in_surface(src_n, cfg.src_size) && in_surface(dst_n, cfg.dst_size);
			out_we_q    <= we_n;
			out_wdata_q <= wdata_n;
			out_fail_q  <= cfg.compare_mode ? fail_n : '0;
			out_done_q  <= !busy_n;
		end
	end

	always_comb begin
		m_tdata                       = '0;
		m_tdata[SADR_LO +: PTR_W]     = out_src_q;
		m_tdata[DADR_LO +: PTR_W]     = out_dst_q;
		m_tdata[WDATA_LO +: PIX_W]    = out_wdata_q;
		m_tdata[FAIL_LO +: FAIL_W]    = out_fail_q;
		m_tuser                       = '0;
		m_tuser[TU_INB]               = out_inb_q;
		m_tuser[TU_WE]                = out_we_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_done_q;

	`RBCC_ASSERT_COMB(a_fail_capped, fail_q <= FAIL_CAP)
	`RBCC_ASSERT_NEXT(a_start_clears, q_pop && q_item.cmd == CMD_START, col_q == '0 && row_q == '0 && fail_q == '0)
	`RBCC_ASSERT_NEXT(a_fail_monotone, q_pop && q_item.cmd == CMD_PIXEL, fail_q >= $past(fail_q))
	`RBCC_ASSERT_IMPL(a_wdata_gated, out_valid_q && !out_we_q, out_wdata_q == '0)

endmodule

// ----- rtl/rect_blit_copy_compare_unit.sv -----
// Top level of the rectangle blit copy/compare unit: config registers and the three parts.
`timescale 1ns / 1ps
// Rectangle blit engine. Program the eight registers (strides, surface sizes, rectangle
// width and height, pixel size, copy or compare mode) while the unit is idle, then send
// a start item (tuser = 0) with the source and destination origins; its result carries
// the first address pair. Each following pixel item (tuser = 1) brings the pixels read at
// the addresses of the previous result and returns the next pair, a write strobe with
// masked data in copy mode, and the running failure count in compare mode. Pixels that
// fall outside either surface are dropped in copy mode and counted as failures in compare
// mode. tlast on the result is high once the rectangle is done (or none is running).
// Throughput is one item per clock unless m_tready holds back the result: the walker updates
// both pointers, the column and row counters and the failure count with one saturating add
// and compare per item. An input item is registered in the two-entry queue behind the front
// end (which does the origin multiply and pixel compare), then in the output register.
module rect_blit_copy_compare_unit #(
	parameter int SIZE_BITS = rbcc_pkg::SIZE_BITS_DEF,   // failure count saturation width
	parameter int DIM_BITS  = rbcc_pkg::DIM_BITS_DEF     // column / row counter width
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// src_x[12:0], src_y[25:13], dst_x[38:26], dst_y[51:39],
	// src_pixel[83:52], dst_pixel[115:84], zero pad to 120
	input  logic [rbcc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// command: 0 start rectangle, 1 pixel step
	input  logic                              s_tuser,
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// src_address[25:0], dst_address[51:26], write_data[83:52],
	// failure_count[107:84], zero pad to 112
	output logic [rbcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// in_bounds[0], write_enable[1]
	output logic [rbcc_pkg::OUT_TUSER_W-1:0]  m_tuser,
	// done_res
	output logic                              m_tlast,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rbcc_pkg::*;

	// rectangle dimensions keep only the low DIM_BITS bits
	localparam logic [RECT_DIM_W-1:0] DIM_MASK = (DIM_BITS >= RECT_DIM_W) ?
		{RECT_DIM_W{1'b1}} : RECT_DIM_W'((64'd1 << DIM_BITS) - 64'd1);
	localparam int ITEM_W = $bits(rbcc_item_t);

	rbcc_cfg_t           cfg_q;
	rbcc_item_t          push_item, pop_item;
	logic [ITEM_W-1:0]   pop_bits;
	logic                q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SRC_STRIDE:   cfg_q.src_stride   <= cfg_data[STRIDE_W-1:0];
				REG_SRC_SIZE:     cfg_q.src_size     <= cfg_data[SURF_W-1:0];
				REG_DST_STRIDE:   cfg_q.dst_stride   <= cfg_data[STRIDE_W-1:0];
				REG_DST_SIZE:     cfg_q.dst_size     <= cfg_data[SURF_W-1:0];
				REG_RECT_WIDTH:   cfg_q.rect_width   <= cfg_data[RECT_DIM_W-1:0] & DIM_MASK;
				REG_RECT_HEIGHT:  cfg_q.rect_height  <= cfg_data[RECT_DIM_W-1:0] & DIM_MASK;
				REG_PIXEL_SIZE:   cfg_q.pixel_size   <= cfg_data[PSIZE_W-1:0];
				REG_COMPARE_MODE: cfg_q.compare_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rbcc_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_item   (push_item),
		.q_full   (q_full)
	);

	rbcc_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_bits),
		.empty     (q_empty)
	);

	assign pop_item = rbcc_item_t'(pop_bits);

	rbcc_back #(
		.SIZE_BITS (SIZE_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_item   (pop_item),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
